// File: src/vmq_pkg.sv
// Shared constants, register indexes and helper functions for the
// vibration motion qualifier. No dependencies.
package vmq_pkg;

  localparam int AGE_BITS     = 24;
  localparam int OUT_BITS     = 24;
  localparam int EDGE_BITS    = 8;
  localparam int CP_BITS      = 4;
  localparam int CW_BITS      = 16;
  localparam int LIM_BITS     = 24;
  localparam int CFG_BITS     = 24;
  localparam int CFG_IDX_BITS = 2;

  typedef logic [AGE_BITS-1:0] age_t;
  typedef logic [CW_BITS-1:0]  win_t;
  typedef logic [CP_BITS-1:0]  tally_t;
  typedef logic [LIM_BITS-1:0] limit_t;
  typedef logic [OUT_BITS-1:0] out_age_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_CONFIRM_PULSES = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CONFIRM_WINDOW = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_QUIET_LIMIT    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LINK_HOLD      = 2'd3;

  localparam tally_t RST_CONFIRM_PULSES = 4'd3;
  localparam win_t   RST_CONFIRM_WINDOW = 16'd3000;
  localparam limit_t RST_QUIET_LIMIT    = 24'd120000;
  localparam limit_t RST_LINK_HOLD      = 24'd60000;

  localparam age_t     AGE_MAX = '1;
  localparam win_t     WIN_MAX = '1;
  localparam out_age_t OUT_MAX = '1;

  function automatic age_t age_inc(input age_t a);
    return (a == AGE_MAX) ? a : a + age_t'(1);
  endfunction

  function automatic win_t win_inc(input win_t a);
    return (a == WIN_MAX) ? a : a + win_t'(1);
  endfunction

  // age below a 24-bit limit, compared at a common width
  function automatic logic below(input age_t a, input limit_t l);
    return 33'(a) < 33'(l);
  endfunction

  function automatic out_age_t clip_out(input age_t a);
    logic [32:0] w;
    w = 33'(a);
    return (w > 33'(OUT_MAX)) ? OUT_MAX : w[OUT_BITS-1:0];
  endfunction

endpackage

// File: src/vibration_motion_qualifier.sv
// Vibration motion qualifier top level: one tick request in, one flag/age result out.
// Depends on vmq_pkg.
//
//   channel   handshake              payload
//   in        in_valid / in_ready    edge_count, link_packet, wake_pin_low, usb_powered
//   out       out_valid / out_ready  moving .. link_quiet_ticks
//   cfg       cfg_we (no wait)       cfg_index, cfg_data
//
// One request per cycle while out_ready is high: state update and result are computed in one pass and
// land in the state and result registers on the accepting edge.
// Result appears the cycle after acceptance; a held result still lets the next
// request in once out_ready is high (in_ready = !out_valid || out_ready).
// Synchronous active-high reset restores register defaults and clears all ages.
module vibration_motion_qualifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vmq_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [vmq_pkg::CFG_BITS-1:0]    cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [vmq_pkg::EDGE_BITS-1:0]   edge_count,
  input  logic                            link_packet,
  input  logic                            wake_pin_low,
  input  logic                            usb_powered,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            moving,
  output logic                            candidate_open,
  output logic                            candidate_rejected,
  output logic                            confirmed_now,
  output logic                            link_active,
  output logic                            sleep_blocked,
  output logic [vmq_pkg::OUT_BITS-1:0]    quiet_ticks,
  output logic [vmq_pkg::OUT_BITS-1:0]    link_quiet_ticks
);

  vmq_pkg::tally_t confirm_pulses;
  vmq_pkg::win_t   confirm_window;
  vmq_pkg::limit_t quiet_limit;
  vmq_pkg::limit_t link_hold;

  logic            motion_seen, motion_seen_next;
  vmq_pkg::age_t   motion_age, motion_age_next;
  vmq_pkg::age_t   uptime_age, uptime_age_next;
  vmq_pkg::tally_t pulse_tally, pulse_tally_next;
  vmq_pkg::win_t   window_age, window_age_next;
  logic            window_open, window_open_next;
  logic            rejected_flag, rejected_flag_next;
  logic            link_seen, link_seen_next;
  vmq_pkg::age_t   link_age, link_age_next;

  logic            confirmed_next, moving_next, link_act_next;
  logic            accept;

  // scratch for the candidate window path
  vmq_pkg::tally_t need, take;
  logic            restart;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    motion_seen_next   = motion_seen;
    motion_age_next    = vmq_pkg::age_inc(motion_age);
    uptime_age_next    = vmq_pkg::age_inc(uptime_age);
    link_age_next      = vmq_pkg::age_inc(link_age);
    window_age_next    = vmq_pkg::win_inc(window_age);
    link_seen_next     = link_seen;
    pulse_tally_next   = pulse_tally;
    window_open_next   = window_open;
    rejected_flag_next = rejected_flag;
    confirmed_next     = 1'b0;
    need               = '0;
    take               = '0;
    restart            = 1'b0;

    if (link_packet) begin
      link_seen_next = 1'b1;
      link_age_next  = '0;
    end

    if (edge_count != '0) begin
      if (motion_seen && vmq_pkg::below(motion_age_next, quiet_limit)) begin
        // live session: edges only refresh it
        motion_age_next    = '0;
        pulse_tally_next   = '0;
        window_age_next    = '0;
        window_open_next   = 1'b0;
        rejected_flag_next = 1'b0;
      end else begin
        restart = !window_open || (window_age_next > confirm_window);
        if (restart) begin
          pulse_tally_next   = '0;
          window_age_next    = '0;
          window_open_next   = 1'b1;
          rejected_flag_next = 1'b0;
        end
        need = (confirm_pulses > pulse_tally_next) ? confirm_pulses - pulse_tally_next : '0;
        take = (edge_count < {4'd0, need}) ? edge_count[vmq_pkg::CP_BITS-1:0] : need;
        pulse_tally_next = pulse_tally_next + take;
        if (pulse_tally_next >= confirm_pulses) begin
          motion_seen_next   = 1'b1;
          motion_age_next    = '0;
          pulse_tally_next   = '0;
          window_age_next    = '0;
          window_open_next   = 1'b0;
          rejected_flag_next = 1'b0;
          confirmed_next     = 1'b1;
        end
      end
    end

    if (window_open_next && (window_age_next >= confirm_window)) begin
      pulse_tally_next   = '0;
      window_age_next    = '0;
      window_open_next   = 1'b0;
      rejected_flag_next = 1'b1;
    end

    moving_next   = motion_seen_next && vmq_pkg::below(motion_age_next, quiet_limit);
    link_act_next = link_seen_next && vmq_pkg::below(link_age_next, link_hold);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      confirm_pulses <= vmq_pkg::RST_CONFIRM_PULSES;
      confirm_window <= vmq_pkg::RST_CONFIRM_WINDOW;
      quiet_limit    <= vmq_pkg::RST_QUIET_LIMIT;
      link_hold      <= vmq_pkg::RST_LINK_HOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        vmq_pkg::REG_CONFIRM_PULSES: confirm_pulses <= cfg_data[vmq_pkg::CP_BITS-1:0];
        vmq_pkg::REG_CONFIRM_WINDOW: confirm_window <= cfg_data[vmq_pkg::CW_BITS-1:0];
        vmq_pkg::REG_QUIET_LIMIT:    quiet_limit    <= cfg_data[vmq_pkg::LIM_BITS-1:0];
        vmq_pkg::REG_LINK_HOLD:      link_hold      <= cfg_data[vmq_pkg::LIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      motion_seen   <= 1'b0;
      motion_age    <= '0;
      uptime_age    <= '0;
      pulse_tally   <= '0;
      window_age    <= '0;
      window_open   <= 1'b0;
      rejected_flag <= 1'b0;
      link_seen     <= 1'b0;
      link_age      <= '0;
    end else if (accept) begin
      motion_seen   <= motion_seen_next;
      motion_age    <= motion_age_next;
      uptime_age    <= uptime_age_next;
      pulse_tally   <= pulse_tally_next;
      window_age    <= window_age_next;
      window_open   <= window_open_next;
      rejected_flag <= rejected_flag_next;
      link_seen     <= link_seen_next;
      link_age      <= link_age_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      moving             <= moving_next;
      candidate_open     <= window_open_next;
      candidate_rejected <= rejected_flag_next;
      confirmed_now      <= confirmed_next;
      link_active        <= link_act_next;
      sleep_blocked      <= usb_powered || wake_pin_low || window_open_next ||
                            moving_next || link_act_next;
      quiet_ticks        <= vmq_pkg::clip_out(motion_seen_next ? motion_age_next
                                                               : uptime_age_next);
      link_quiet_ticks   <= link_seen_next ? vmq_pkg::clip_out(link_age_next)
                                           : vmq_pkg::OUT_MAX;
    end
  end

endmodule

// File: src/vmq_checker.sv
// Port-level checker for the vibration motion qualifier, bound to the top level.
// Depends on vmq_pkg.
module vmq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            moving,
  input logic                            candidate_open,
  input logic                            candidate_rejected,
  input logic                            confirmed_now,
  input logic                            link_active,
  input logic                            sleep_blocked,
  input logic [vmq_pkg::OUT_BITS-1:0]    quiet_ticks,
  input logic [vmq_pkg::OUT_BITS-1:0]    link_quiet_ticks
);

  // a confirmation closes the window
  a_confirm_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && confirmed_now |-> !candidate_open)
    else $error("window still open on confirmation");

  // rejection only happens as the window drops
  a_reject_closed: assert property (@(posedge clk) disable iff (rst)
    out_valid && candidate_rejected |-> !candidate_open)
    else $error("rejected flag with open window");

  a_sleep_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && (candidate_open || moving || link_active) |-> sleep_blocked)
    else $error("sleep not blocked");

  // link hold fits in 24 bits, so an active link never shows the saturated age
  a_link_age: assert property (@(posedge clk) disable iff (rst)
    out_valid && link_active |-> link_quiet_ticks != vmq_pkg::OUT_MAX)
    else $error("link active with saturated quiet age");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quiet_ticks) && $stable(moving))
    else $error("stalled request changed");

endmodule

bind vibration_motion_qualifier vmq_checker u_vmq_checker (.*);

// File: tb/vibration_motion_qualifier_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for vibration_motion_qualifier: a scoreboard class predicts
// each tick's flags and quiet times, plain tasks drive ticks and register writes.
// Depends on vmq_pkg and the vibration_motion_qualifier RTL.
module vibration_motion_qualifier_tb;

  localparam int RUN_LIMIT = 400000;

  typedef logic [vmq_pkg::EDGE_BITS-1:0] edges_t;
  typedef logic [vmq_pkg::CFG_BITS-1:0]  cfg_word_t;

  typedef struct packed {
    edges_t edges;
    logic   pkt;
    logic   pin_low;
    logic   usb;
  } tick_t;

  typedef struct packed {
    logic              moving;
    logic              cand_open;
    logic              rejected;
    logic              confirmed;
    logic              link_act;
    logic              sleep_blk;
    vmq_pkg::out_age_t quiet;
    vmq_pkg::out_age_t link_quiet;
  } tick_result_t;

  class motion_scoreboard;
    vmq_pkg::tally_t need_pulses;
    vmq_pkg::win_t   win_len;
    vmq_pkg::limit_t quiet_lim;
    vmq_pkg::limit_t hold_lim;

    bit              motion_seen;
    vmq_pkg::age_t   motion_age;
    vmq_pkg::age_t   uptime_age;
    vmq_pkg::tally_t tally;
    vmq_pkg::win_t   win_age;
    bit              win_open;
    bit              rejected;
    bit              link_seen;
    vmq_pkg::age_t   link_age;

    tick_result_t awaited_status[$];
    int errors;
    int results_seen;

    function new();
      need_pulses  = vmq_pkg::RST_CONFIRM_PULSES;
      win_len      = vmq_pkg::RST_CONFIRM_WINDOW;
      quiet_lim    = vmq_pkg::RST_QUIET_LIMIT;
      hold_lim     = vmq_pkg::RST_LINK_HOLD;
      motion_seen  = 0;
      motion_age   = '0;
      uptime_age   = '0;
      tally        = '0;
      win_age      = '0;
      win_open     = 0;
      rejected     = 0;
      link_seen    = 0;
      link_age     = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [vmq_pkg::CFG_IDX_BITS-1:0] idx, cfg_word_t val);
      case (idx)
        vmq_pkg::REG_CONFIRM_PULSES: need_pulses = val[vmq_pkg::CP_BITS-1:0];
        vmq_pkg::REG_CONFIRM_WINDOW: win_len     = val[vmq_pkg::CW_BITS-1:0];
        vmq_pkg::REG_QUIET_LIMIT:    quiet_lim   = val[vmq_pkg::LIM_BITS-1:0];
        vmq_pkg::REG_LINK_HOLD:      hold_lim    = val[vmq_pkg::LIM_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void drop_window();
      tally    = '0;
      win_age  = '0;
      win_open = 0;
    endfunction

    // one millisecond tick: ages first, then link, edges, window timeout
    function tick_result_t advance_tick(tick_t t);
      tick_result_t r;
      int need;
      int take;
      bit confirmed;
      bit mov;
      bit lact;
      confirmed = 0;
      if (motion_age != '1) motion_age = motion_age + 1'b1;
      if (uptime_age != '1) uptime_age = uptime_age + 1'b1;
      if (link_age != '1) link_age = link_age + 1'b1;
      if (win_age != '1) win_age = win_age + 1'b1;

      if (t.pkt) begin
        link_seen = 1;
        link_age  = '0;
      end

      if (t.edges != 0) begin
        if (motion_seen && motion_age < quiet_lim) begin
          motion_age = '0;
          drop_window();
          rejected = 0;
        end else begin
          if (!win_open || win_age > win_len) begin
            tally    = '0;
            win_age  = '0;
            win_open = 1;
            rejected = 0;
          end
          need = (need_pulses > tally) ? int'(need_pulses) - int'(tally) : 0;
          take = (int'(t.edges) < need) ? int'(t.edges) : need;
          tally = tally + vmq_pkg::tally_t'(take);
          if (tally >= need_pulses) begin
            motion_seen = 1;
            motion_age  = '0;
            drop_window();
            rejected  = 0;
            confirmed = 1;
          end
        end
      end

      if (win_open && win_age >= win_len) begin
        drop_window();
        rejected = 1;
      end

      mov  = motion_seen && motion_age < quiet_lim;
      lact = link_seen && link_age < hold_lim;
      r.moving     = mov;
      r.cand_open  = win_open;
      r.rejected   = rejected;
      r.confirmed  = confirmed;
      r.link_act   = lact;
      r.sleep_blk  = t.usb || t.pin_low || win_open || mov || lact;
      r.quiet      = motion_seen ? motion_age : uptime_age;
      r.link_quiet = link_seen ? link_age : '1;
      return r;
    endfunction

    function void note_tick(tick_t t);
      awaited_status.push_back(advance_tick(t));
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH: %s", what);
    endtask

    task check_result(tick_result_t got);
      tick_result_t want;
      if (awaited_status.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = awaited_status.pop_front();
      results_seen++;
      if (got.moving !== want.moving)
        report($sformatf("result %0d moving got %b want %b",
                         results_seen, got.moving, want.moving));
      if (got.cand_open !== want.cand_open)
        report($sformatf("result %0d candidate_open got %b want %b",
                         results_seen, got.cand_open, want.cand_open));
      if (got.rejected !== want.rejected)
        report($sformatf("result %0d candidate_rejected got %b want %b",
                         results_seen, got.rejected, want.rejected));
      if (got.confirmed !== want.confirmed)
        report($sformatf("result %0d confirmed_now got %b want %b",
                         results_seen, got.confirmed, want.confirmed));
      if (got.link_act !== want.link_act)
        report($sformatf("result %0d link_active got %b want %b",
                         results_seen, got.link_act, want.link_act));
      if (got.sleep_blk !== want.sleep_blk)
        report($sformatf("result %0d sleep_blocked got %b want %b",
                         results_seen, got.sleep_blk, want.sleep_blk));
      if (got.quiet !== want.quiet)
        report($sformatf("result %0d quiet_ticks got %0d want %0d",
                         results_seen, got.quiet, want.quiet));
      if (got.link_quiet !== want.link_quiet)
        report($sformatf("result %0d link_quiet_ticks got %0d want %0d",
                         results_seen, got.link_quiet, want.link_quiet));
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [vmq_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  cfg_word_t                        cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  edges_t                           edge_count = '0;
  logic                             link_packet = 1'b0;
  logic                             wake_pin_low = 1'b0;
  logic                             usb_powered = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             moving;
  logic                             candidate_open;
  logic                             candidate_rejected;
  logic                             confirmed_now;
  logic                             link_active;
  logic                             sleep_blocked;
  logic [vmq_pkg::OUT_BITS-1:0]     quiet_ticks;
  logic [vmq_pkg::OUT_BITS-1:0]     link_quiet_ticks;

  motion_scoreboard sb;
  tick_t            offered;
  tick_result_t     observed;
  int               cycle_count = 0;
  int               ticks_sent = 0;
  bit               send_steady = 0;

  assign offered  = {edge_count, link_packet, wake_pin_low, usb_powered};
  assign observed = {moving, candidate_open, candidate_rejected, confirmed_now,
                     link_active, sleep_blocked, quiet_ticks, link_quiet_ticks};

  vibration_motion_qualifier dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .edge_count         (edge_count),
    .link_packet        (link_packet),
    .wake_pin_low       (wake_pin_low),
    .usb_powered        (usb_powered),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .moving             (moving),
    .candidate_open     (candidate_open),
    .candidate_rejected (candidate_rejected),
    .confirmed_now      (confirmed_now),
    .link_active        (link_active),
    .sleep_blocked      (sleep_blocked),
    .quiet_ticks        (quiet_ticks),
    .link_quiet_ticks   (link_quiet_ticks)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // results are checked before the same edge's request is noted
  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (out_valid && out_ready) sb.check_result(observed);
      if (in_valid && in_ready) sb.note_tick(offered);
    end
  end

  // receiver: random stalls, stall-free stretches, two long hold-offs
  initial begin : drain_results
    int stall;
    int taken;
    bit steady;
    taken  = 0;
    steady = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      if (taken == 150 || taken == 600) stall = 300;
      else stall = steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      taken++;
    end
  end

  function automatic tick_t tick_of(int e, bit p, bit w, bit u);
    tick_t t;
    t.edges   = e[vmq_pkg::EDGE_BITS-1:0];
    t.pkt     = p;
    t.pin_low = w;
    t.usb     = u;
    return t;
  endfunction

  // active: a burst edge count; silent: no edges; otherwise edges drawn across the whole range
  function automatic tick_t random_tick(bit active, bit silent);
    tick_t t;
    int pick;
    pick = $urandom_range(0, 99);
    if (silent) t.edges = '0;
    else if (active) t.edges = edges_t'($urandom_range(1, 3));
    else if (pick < 50) t.edges = '0;
    else if (pick < 85) t.edges = edges_t'($urandom_range(1, 4));
    else t.edges = edges_t'($urandom_range(0, 255));
    t.pkt     = ($urandom_range(0, 5) == 0);
    t.pin_low = ($urandom_range(0, 4) == 0);
    t.usb     = ($urandom_range(0, 4) == 0);
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    int gap;
    if (ticks_sent % 40 == 0) send_steady = ($urandom_range(0, 3) == 0);
    gap = send_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    edge_count   <= t.edges;
    link_packet  <= t.pkt;
    wake_pin_low <= t.pin_low;
    usb_powered  <= t.usb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  // mostly edge bursts followed by quiet runs long enough to expire windows
  // and sessions; the rest is unstructured noise
  task automatic drive_random(int count, int span);
    int done;
    int n;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 9) < 6) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_tick(random_tick(1, 0));
          done++;
        end
        n = $urandom_range(0, span);
        repeat (n) begin
          send_tick(random_tick(0, 1));
          done++;
        end
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          send_tick(random_tick(0, 0));
          done++;
        end
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [vmq_pkg::CFG_IDX_BITS-1:0] idx, cfg_word_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic program_regs(vmq_pkg::tally_t cp, vmq_pkg::win_t cw,
                              vmq_pkg::limit_t ql, vmq_pkg::limit_t lh);
    write_reg(vmq_pkg::REG_CONFIRM_PULSES, cfg_word_t'(cp));
    write_reg(vmq_pkg::REG_CONFIRM_WINDOW, cfg_word_t'(cw));
    write_reg(vmq_pkg::REG_QUIET_LIMIT, cfg_word_t'(ql));
    write_reg(vmq_pkg::REG_LINK_HOLD, cfg_word_t'(lh));
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: idle tick, excess edges confirm at once, session refresh
    send_tick(tick_of(0, 0, 0, 0));
    send_tick(tick_of(255, 1, 1, 1));
    send_tick(tick_of(1, 0, 0, 0));
    send_tick(tick_of(0, 1, 0, 0));
    send_tick(tick_of(128, 0, 1, 0));
    send_tick(tick_of(127, 0, 0, 1));
    drive_random(40, 50);
    settle();

    // short window and limits: windows time out and sessions end often
    program_regs(4'd2, 16'd5, 24'd20, 24'd10);
    drive_random(250, 30);
    settle();

    // zero pulse count and zero limits: any edge confirms, never moving/linked
    program_regs(4'd0, 16'd0, 24'd0, 24'd0);
    send_tick(tick_of(0, 1, 0, 0));
    send_tick(tick_of(1, 0, 0, 0));
    send_tick(tick_of(5, 1, 1, 0));
    drive_random(30, 4);
    settle();

    // zero window: an unconfirmed window is rejected on the tick it opens
    program_regs(4'd2, 16'd0, 24'd0, 24'd0);
    send_tick(tick_of(1, 0, 0, 0));
    send_tick(tick_of(3, 0, 0, 0));
    send_tick(tick_of(255, 0, 0, 0));
    drive_random(30, 4);
    settle();

    // widest settings: tally accumulates over several ticks up to 15
    program_regs(4'd15, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_tick(tick_of(7, 0, 0, 0));
    send_tick(tick_of(7, 1, 0, 0));
    send_tick(tick_of(0, 0, 0, 0));
    send_tick(tick_of(1, 0, 0, 0));
    send_tick(tick_of(200, 0, 0, 0));
    drive_random(40, 40);
    settle();

    program_regs(4'd1, 16'd1, 24'd1, 24'd1);
    drive_random(100, 6);
    settle();

    repeat (3) begin
      program_regs(vmq_pkg::tally_t'($urandom_range(1, 15)),
                   vmq_pkg::win_t'($urandom_range(2, 40)),
                   vmq_pkg::limit_t'($urandom_range(5, 200)),
                   vmq_pkg::limit_t'($urandom_range(3, 100)));
      drive_random(120, 60);
      settle();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/vmq_pkg.sv
src/vibration_motion_qualifier.sv
src/vmq_checker.sv
tb/vibration_motion_qualifier_tb.sv
